/* rtl/sdse_pkg.sv */
// ---------------------------------------------------------------------------
// sdse_pkg
// Shared command codes, geometry constants and the decoded command type.
// ---------------------------------------------------------------------------
package sdse_pkg;

   localparam logic [2:0] OP_DRAW   = 3'd0;
   localparam logic [2:0] OP_DOWN   = 3'd1;
   localparam logic [2:0] OP_RIGHT  = 3'd2;
   localparam logic [2:0] OP_LEFT   = 3'd3;
   localparam logic [2:0] OP_HIRES  = 3'd4;
   localparam logic [2:0] OP_LORES  = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;

   localparam int WORD_BITS  = 16;
   localparam int LO_WIDTH   = 64;
   localparam int LO_HEIGHT  = 32;
   localparam int LO_WORDS   = LO_WIDTH / WORD_BITS;
   localparam int SHIFT_STEP = 4;
   localparam int CMDQ_DEPTH = 2;

   // command as it leaves the front end
   typedef struct packed {
      logic [2:0]  op;
      logic        hires;   // resolution flag after this command
      logic        skip;    // draw row lands below the bottom edge
      logic [7:0]  x;       // wrapped start column for draw, raw column for read
      logic [7:0]  y;       // target row for draw, raw row for read
      logic [15:0] bits;
      logic [3:0]  amt;
   } cmd_type;

endpackage

/* rtl/sdse_ram.sv */
// ---------------------------------------------------------------------------
// sdse_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module sdse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/sdse_front.sv */
// ---------------------------------------------------------------------------
// sdse_front
// Command decode: wraps draw positions against the active screen and tracks
// the resolution flag in command order.
// ---------------------------------------------------------------------------
module sdse_front import sdse_pkg::*; #(
   parameter int HI_WIDTH  = 128,
   parameter int HI_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [3:0]  req_row_index,
   input  logic [15:0] req_sprite_row,
   input  logic [3:0]  req_scroll_amount,
   output cmd_type     cmd
);

   logic        hires_ff;
   logic        hires_in;
   logic [11:0] span_w;
   logic [11:0] span_h;
   logic [7:0]  x_start;
   logic [7:0]  y_row;

   // remainder by restoring subtraction, quotient is at most 7 here
   function automatic logic [7:0] wrap_pos(input logic [7:0] v, input logic [11:0] span);
      logic [11:0] r;
      r = {4'b0, v};
      for (int k = 2; k >= 0; k--) begin
         if (r >= (span << k)) begin
            r = r - (span << k);
         end
      end
      return r[7:0];
   endfunction

   always_comb begin
      span_w  = hires_ff ? 12'(HI_WIDTH) : 12'(LO_WIDTH);
      span_h  = hires_ff ? 12'(HI_HEIGHT) : 12'(LO_HEIGHT);
      x_start = wrap_pos(req_pos_x, span_w);
      y_row   = wrap_pos(req_pos_y, span_h) + {4'b0, req_row_index};

      cmd.op   = req_opcode;
      cmd.bits = req_sprite_row;
      cmd.amt  = req_scroll_amount;
      cmd.skip = 1'b0;
      cmd.x    = req_pos_x;
      cmd.y    = req_pos_y;
      if (req_opcode == OP_DRAW) begin
         cmd.x    = x_start;
         cmd.y    = y_row;
         cmd.skip = {4'b0, y_row} >= span_h;
      end

      case (req_opcode)
         OP_HIRES: cmd.hires = 1'b1;
         OP_LORES: cmd.hires = 1'b0;
         default:  cmd.hires = hires_ff;
      endcase

      hires_in = accept ? cmd.hires : hires_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hires_ff <= 1'b0;
      end else begin
         hires_ff <= hires_in;
      end
   end

endmodule

/* rtl/sdse_cmdq.sv */
// ---------------------------------------------------------------------------
// sdse_cmdq
// Short command queue between the decode front end and the store engine.
// ---------------------------------------------------------------------------
module sdse_cmdq import sdse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          entries_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(CMDQ_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      full      = count_ff == CNT_W'(CMDQ_DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head      = entries_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* rtl/sdse_back.sv */
// ---------------------------------------------------------------------------
// sdse_back
// Store engine: clears the frame store after reset, then runs draw, read and
// scroll commands against it and holds the result beat.
// ---------------------------------------------------------------------------
module sdse_back import sdse_pkg::*; #(
   parameter int HI_WIDTH  = 128,
   parameter int HI_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_pop,
   output logic        rsp_collision,
   output logic [15:0] rsp_read_data,
   output logic        rsp_hires_mode
);

   localparam int WPR         = HI_WIDTH / WORD_BITS;
   localparam int STORE_WORDS = WPR * HI_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int ROW_W       = $clog2(HI_HEIGHT);
   localparam int COL_W       = $clog2(WPR);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_W1,
      S_W2,
      S_SCROLL,
      S_FLUSH,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              coll_ff, coll_in;
   logic [15:0]       rd_ff, rd_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  k_ff, k_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              wr_zero_ff, wr_zero_in;
   logic              wr_first_ff, wr_first_in;
   logic [15:0]       carry_ff, carry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_coll_ff, rsp_coll_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_hires_ff, rsp_hires_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [15:0]       ram_rdata;

   cmd_type           cur;
   logic [4:0]        ww;
   logic [4:0]        ww_head;
   logic [4:0]        col;
   logic [4:0]        wi1;
   logic              last_col;
   logic [ADDR_W-1:0] addr0;
   logic [ADDR_W-1:0] addr1;
   logic [ADDR_W-1:0] dest;
   logic [31:0]       mask;
   logic [31:0]       joined;
   logic              row_ok;
   logic              valid0;
   logic              valid1;
   logic              in1;
   logic [7:0]        src_rows;
   logic              zero_row;
   logic [15:0]       carry_eff;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [7:0] r, input logic [4:0] c);
      logic [12:0] a;
      a = 13'(r) * 13'(WPR) + 13'(c);
      return a[ADDR_W-1:0];
   endfunction

   sdse_ram #(
      .WIDTH (16),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      // the first access is issued from the queue head in the pop cycle
      cur      = (state_ff == S_IDLE) ? q_head : cmd_ff;
      wi1      = {1'b0, cur.x[7:4]} + 5'd1;
      addr0    = addr_of(cur.y, {1'b0, cur.x[7:4]});
      addr1    = addr_of(cur.y, wi1);
      ww       = cmd_ff.hires ? 5'(WPR) : 5'(LO_WORDS);
      ww_head  = q_head.hires ? 5'(WPR) : 5'(LO_WORDS);
      mask     = {cmd_ff.bits, 16'b0} >> cmd_ff.x[3:0];
      row_ok   = {1'b0, cmd_ff.y} < 9'(HI_HEIGHT);
      valid0   = row_ok && ({1'b0, cmd_ff.x[7:4]} < 5'(WPR));
      valid1   = row_ok && (wi1 < 5'(WPR));
      in1      = wi1 < ww;
      joined   = {rd_ff, valid1 ? ram_rdata : 16'b0} << cmd_ff.x[3:0];
      last_col = 5'(k_ff) == ww - 5'd1;
      col      = (cmd_ff.op == OP_LEFT) ? (ww - 5'd1 - 5'(k_ff)) : 5'(k_ff);
      dest     = addr_of(8'(row_ff), col);
      // only a scroll down moves words between rows
      src_rows = (cmd_ff.op == OP_DOWN) ? 8'(cmd_ff.amt) : 8'd0;
      zero_row = 8'(row_ff) < src_rows;
      carry_eff = wr_first_ff ? 16'b0 : carry_ff;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      clr_in       = clr_ff;
      coll_in      = coll_ff;
      rd_in        = rd_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_zero_in   = wr_zero_ff;
      wr_first_in  = wr_first_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_coll_in  = rsp_coll_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_hires_in = rsp_hires_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      // scroll write stage, fed by wr_pend_ff with the read data that S_SCROLL requested
      if (wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         carry_in  = ram_rdata;
         case (cmd_ff.op)
            OP_RIGHT: ram_wdata = {carry_eff[SHIFT_STEP-1:0], ram_rdata[15:SHIFT_STEP]};
            OP_LEFT:  ram_wdata = {ram_rdata[15-SHIFT_STEP:0], carry_eff[15:16-SHIFT_STEP]};
            default:  ram_wdata = wr_zero_ff ? 16'b0 : ram_rdata;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               cmd_in  = q_head;
               coll_in = 1'b0;
               rd_in   = '0;
               row_in  = q_head.hires ? ROW_W'(HI_HEIGHT - 1) : ROW_W'(LO_HEIGHT - 1);
               k_in    = '0;
               ram_raddr = addr0;
               case (q_head.op)
                  OP_DRAW:  state_in = q_head.skip ? S_DONE : S_W1;
                  OP_READ:  state_in = S_W1;
                  OP_DOWN, OP_RIGHT, OP_LEFT: begin
                     state_in = (ww_head == '0) ? S_DONE : S_SCROLL;
                  end
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_W1: begin
            ram_raddr = addr1;
            if (cmd_ff.op == OP_DRAW) begin
               ram_we    = 1'b1;
               ram_waddr = addr0;
               ram_wdata = ram_rdata ^ mask[31:16];
               coll_in   = |(ram_rdata & mask[31:16]);
            end else begin
               rd_in = valid0 ? ram_rdata : 16'b0;
            end
            state_in = S_W2;
         end
         S_W2: begin
            if (cmd_ff.op == OP_DRAW) begin
               if (in1) begin
                  ram_we    = 1'b1;
                  ram_waddr = addr1;
                  ram_wdata = ram_rdata ^ mask[15:0];
                  coll_in   = coll_ff | (|(ram_rdata & mask[15:0]));
               end
            end else begin
               rd_in = joined[31:16];
            end
            state_in = S_DONE;
         end
         S_SCROLL: begin
            wr_pend_in  = 1'b1;
            wr_addr_in  = dest;
            wr_zero_in  = zero_row;
            wr_first_in = k_ff == '0;
            ram_raddr   = zero_row ? dest
                                   : addr_of(8'(row_ff) - src_rows, col);
            if (last_col) begin
               k_in = '0;
               if (row_ff == '0) begin
                  state_in = S_FLUSH;
               end else begin
                  row_in = row_ff - ROW_W'(1);
               end
            end else begin
               k_in = k_ff + COL_W'(1);
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_coll_in  = coll_ff;
               rsp_data_in  = rd_ff;
               rsp_hires_in = cmd_ff.hires;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      coll_ff      <= coll_in;
      rd_ff        <= rd_in;
      row_ff       <= row_in;
      k_ff         <= k_in;
      wr_addr_ff   <= wr_addr_in;
      wr_zero_ff   <= wr_zero_in;
      wr_first_ff  <= wr_first_in;
      carry_ff     <= carry_in;
      rsp_coll_ff  <= rsp_coll_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_hires_ff <= rsp_hires_in;
   end

   assign clearing       = state_ff == S_CLEAR;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_collision  = rsp_coll_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_hires_mode = rsp_hires_ff;

`ifndef SYNTHESIS
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop)
      else $error("command taken during store clear");

   a_scroll_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL && wr_pend_ff) |-> (ram_raddr != ram_waddr))
      else $error("scroll read hits the word being written");

   a_draw_second_word_differs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W2 && ram_we) |-> (ram_waddr != addr0))
      else $error("draw second word aliases the first");

   a_flush_has_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> wr_pend_ff)
      else $error("scroll flush without a pending write");
`endif

endmodule

/* rtl/schip_display_scroll_sprite_engine_core.sv */
// ---------------------------------------------------------------------------
// schip_display_scroll_sprite_engine_core
// Super-CHIP-8 style monochrome framebuffer with sprite row draw, scrolls,
// resolution switch and word read.
// ---------------------------------------------------------------------------
// After reset the block clears its frame store one word per cycle and holds
// full high while it clears. Commands are decoded on entry and wait in a
// two-deep queue; one result beat comes back for every command, in order. In
// the store engine a draw row reads two words and writes back the first and,
// when it lies on the active screen, the second, through the single RAM port
// pair; a read fetches two words; a resolution change, an unused opcode or a
// draw row that lands below the bottom edge writes no word; and a scroll
// walks the active screen one word per cycle.
// HI_WIDTH must be a multiple of 16.
module schip_display_scroll_sprite_engine_core import sdse_pkg::*; #(
   parameter int HI_WIDTH  = 128,
   parameter int HI_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [3:0]  req_row_index,
   input  logic [15:0] req_sprite_row,
   input  logic [3:0]  req_scroll_amount,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_collision,
   output logic [15:0] rsp_read_data,
   output logic        rsp_hires_mode
);

   cmd_type front_cmd;
   cmd_type q_head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   logic    clearing;
   logic    accept;
   logic    rsp_valid;

   assign full   = q_full || clearing;
   assign accept = push && !full;
   assign empty  = !rsp_valid;

   sdse_front #(
      .HI_WIDTH  (HI_WIDTH),
      .HI_HEIGHT (HI_HEIGHT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_opcode        (req_opcode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_row_index     (req_row_index),
      .req_sprite_row    (req_sprite_row),
      .req_scroll_amount (req_scroll_amount),
      .cmd               (front_cmd)
   );

   sdse_cmdq u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .din   (front_cmd),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (q_head)
   );

   sdse_back #(
      .HI_WIDTH  (HI_WIDTH),
      .HI_HEIGHT (HI_HEIGHT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_pop        (pop && rsp_valid),
      .rsp_collision  (rsp_collision),
      .rsp_read_data  (rsp_read_data),
      .rsp_hires_mode (rsp_hires_mode)
   );

endmodule
